// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the GPIO register bank.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define GPR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that is also checked during reset.
`define GPR_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// ===== rtl/gpr_pkg.sv =====
// Types and constants of the GPIO register bank.
package gpr_pkg;

   localparam int unsigned DATA_W      = 32;
   localparam int unsigned ADDR_W      = 9;
   localparam int unsigned PINS        = 32;
   localparam int unsigned FUNC_W      = 3;
   localparam int unsigned NIBBLE_W    = 4;
   localparam int unsigned FUNC_PINS   = 8;   // pins per function word
   localparam int unsigned WORD_ADDR_W = ADDR_W - 2;
   localparam int unsigned BANK_IDX_W  = 4;   // bank field of the decoder
   localparam int unsigned OFS_W       = 4;   // word offset inside a bank
   localparam int unsigned OFS_BYTE_W  = OFS_W + 2;

   // Bank stride, fixed by the register map
   localparam int unsigned STRIDE_BYTES = 36;
   localparam int unsigned STRIDE_WORDS = STRIDE_BYTES / 4;

   // word / 9 == (word * 57) >> 9, exact for word addresses below 128
   localparam int unsigned        PROD_W      = WORD_ADDR_W + 6;
   localparam logic [PROD_W-1:0]  RECIP_MUL   = PROD_W'(57);
   localparam int unsigned        RECIP_SHIFT = 9;

   // Byte offsets inside a bank
   localparam logic [OFS_BYTE_W-1:0] OFS_DATA  = 6'h10;
   localparam logic [OFS_BYTE_W-1:0] OFS_PULL0 = 6'h1C;
   localparam logic [OFS_BYTE_W-1:0] OFS_PULL1 = 6'h20;

   // Function code of an output pin
   localparam logic [FUNC_W-1:0] FUNC_OUTPUT = 3'd1;

   typedef logic [PINS-1:0][FUNC_W-1:0] func_row_type;
   typedef logic [1:0][DATA_W-1:0]      pull_row_type;

   // Decoded address of one bus word
   typedef struct packed {
      logic [BANK_IDX_W-1:0] bank;
      logic                  bank_oob;
      logic                  is_func;
      logic [1:0]            func_sel;
      logic                  is_data;
      logic                  is_pull;
      logic                  pull_sel;
      logic                  unmapped;
   } dec_type;

endpackage

// ===== rtl/gpr_if.sv =====
// Handshake interfaces of the request and response channels.
interface gpr_req_if;
   logic                       valid;
   logic                       ready;
   logic                       kind;
   logic [gpr_pkg::ADDR_W-1:0] addr;
   logic [gpr_pkg::DATA_W-1:0] write_data;
   logic [gpr_pkg::PINS-1:0]   pad_levels;

   modport source (output valid, kind, addr, write_data, pad_levels, input ready);
   modport sink   (input valid, kind, addr, write_data, pad_levels, output ready);
endinterface

interface gpr_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [gpr_pkg::DATA_W-1:0] read_data;
   logic                       addr_error;
   logic [gpr_pkg::PINS-1:0]   bank_out_enable;
   logic [gpr_pkg::PINS-1:0]   bank_out_value;

   modport source (output valid, read_data, addr_error, bank_out_enable, bank_out_value,
                   input ready);
   modport sink   (input valid, read_data, addr_error, bank_out_enable, bank_out_value,
                   output ready);
endinterface

// ===== rtl/gpr_decode.sv =====
// Address decoder: bank index and register offset of a bus byte address.
module gpr_decode #(
   parameter int BANKS = 8
) (
   input  logic [gpr_pkg::ADDR_W-1:0] addr,
   output gpr_pkg::dec_type           dec
);
   import gpr_pkg::*;

   logic [WORD_ADDR_W-1:0] word;
   logic [PROD_W-1:0]      prod;
   logic [BANK_IDX_W-1:0]  bank;
   logic [WORD_ADDR_W-1:0] base;
   logic [OFS_W-1:0]       ofs;
   logic [OFS_BYTE_W-1:0]  ofs_byte;

   // Bank = word / 9 by reciprocal multiply, offset = remainder
   assign word     = addr[ADDR_W-1:2];
   assign prod     = PROD_W'(word) * RECIP_MUL;
   assign bank     = prod[RECIP_SHIFT +: BANK_IDX_W];
   assign base     = WORD_ADDR_W'(bank * STRIDE_WORDS);
   assign ofs      = OFS_W'(word - base);
   assign ofs_byte = {ofs, 2'b00};

   // Register select
   always_comb begin
      dec          = '0;
      dec.bank     = bank;
      dec.bank_oob = ({1'b0, bank} >= (BANK_IDX_W + 1)'(BANKS));
      dec.func_sel = ofs[1:0];
      dec.pull_sel = (ofs_byte == OFS_PULL1);
      dec.is_func  = (ofs_byte < OFS_DATA);
      dec.is_data  = (ofs_byte == OFS_DATA);
      dec.is_pull  = (ofs_byte == OFS_PULL0) || (ofs_byte == OFS_PULL1);
      dec.unmapped = !(dec.is_func || dec.is_data || dec.is_pull);
   end

endmodule

// ===== rtl/gpio_port_register_bank_unit.sv =====
// Top level of the GPIO register bank: storage, access logic and handshake stages.
//
//   channel  dir  word                                                  accepted at
//   req      in   kind, addr, write_data, pad_levels                    valid & ready
//   rsp      out  read_data, addr_error, bank_out_enable, bank_out_value valid & ready
//
// One word per cycle sustained while rsp is not stalled; a result word passes through the
// input register, then the result register, before it can be taken.
// Reset clears all function, data and pull registers, so pins start as inputs.
// The access and its read-modify-write happen as the input stage moves to the result
// register; while the result register is full and rsp is stalled, the input stage holds
// and req_port.ready drops once it too is full.
`include "assert_macros.svh"

module gpio_port_register_bank_unit #(
   parameter int BANKS = 8
) (
   input logic     clock,
   input logic     reset,
   gpr_req_if.sink   req_port,
   gpr_rsp_if.source rsp_port
);
   import gpr_pkg::*;

   localparam int BANK_W = (BANKS > 1) ? $clog2(BANKS) : 1;

   // Storage
   func_row_type            func_row_ff [BANKS];
   logic [DATA_W-1:0]       latch_ff    [BANKS];
   pull_row_type            pull_ff     [BANKS];

   // Input stage
   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_kind_ff;
   logic [ADDR_W-1:0]       s1_addr_ff;
   logic [DATA_W-1:0]       s1_wdata_ff;
   logic [PINS-1:0]         s1_pads_ff;

   // Result stage
   logic                    out_valid_ff, out_valid_in;
   logic [DATA_W-1:0]       rd_ff, rd_in;
   logic                    err_ff, err_in;
   logic [PINS-1:0]         oe_ff, oe_in;
   logic [PINS-1:0]         ov_ff, ov_in;

   logic                    advance;
   logic                    req_take;
   logic                    wr_ok;
   dec_type                 dec;
   logic [BANK_W-1:0]       bidx;
   func_row_type            row_cur;
   func_row_type            row_after;
   logic [DATA_W-1:0]       latch_cur;
   logic [DATA_W-1:0]       latch_after;
   pull_row_type            pull_cur;
   logic [DATA_W-1:0]       func_word;
   logic [PINS-1:0]         oe_cur;

   gpr_decode #(.BANKS(BANKS)) u_decode (
      .addr (s1_addr_ff),
      .dec  (dec)
   );

   // Handshake control
   assign advance        = s1_valid_ff && (!out_valid_ff || rsp_port.ready);
   assign req_port.ready = !s1_valid_ff || advance;
   assign req_take       = req_port.valid && req_port.ready;
   assign s1_valid_in    = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign out_valid_in   = advance ? 1'b1 : (rsp_port.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_kind_ff  <= req_port.kind;
         s1_addr_ff  <= req_port.addr;
         s1_wdata_ff <= req_port.write_data;
         s1_pads_ff  <= req_port.pad_levels;
      end
   end

   // Addressed bank rows
   assign bidx      = dec.bank_oob ? '0 : dec.bank[BANK_W-1:0];
   assign row_cur   = func_row_ff[bidx];
   assign latch_cur = latch_ff[bidx];
   assign pull_cur  = pull_ff[bidx];
   assign wr_ok     = s1_kind_ff && !dec.bank_oob;

   // Function word read view and write merge (bit 3 of each nibble not stored)
   always_comb begin
      row_after = row_cur;
      func_word = '0;
      for (int k = 0; k < FUNC_PINS; k++) begin
         func_word[k*NIBBLE_W +: NIBBLE_W] = {1'b0, row_cur[{dec.func_sel, 3'(k)}]};
         if (wr_ok && dec.is_func)
            row_after[{dec.func_sel, 3'(k)}] = s1_wdata_ff[k*NIBBLE_W +: FUNC_W];
      end
   end

   assign latch_after = (wr_ok && dec.is_data) ? s1_wdata_ff : latch_cur;

   // Output-enable masks before and after the access
   always_comb begin
      oe_cur = '0;
      oe_in  = '0;
      for (int p = 0; p < PINS; p++) begin
         oe_cur[p] = (row_cur[p] == FUNC_OUTPUT);
         oe_in[p]  = (row_after[p] == FUNC_OUTPUT) && !dec.bank_oob;
      end
   end

   // Result word
   always_comb begin
      err_in = dec.bank_oob || dec.unmapped;
      ov_in  = dec.bank_oob ? '0 : latch_after;
      rd_in  = '0;
      if (!s1_kind_ff && !err_in) begin
         if (dec.is_func)
            rd_in = func_word;
         else if (dec.is_data)
            rd_in = (latch_cur & oe_cur) | (s1_pads_ff & ~oe_cur);
         else
            rd_in = pull_cur[dec.pull_sel];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rd_ff  <= rd_in;
         err_ff <= err_in;
         oe_ff  <= oe_in;
         ov_ff  <= ov_in;
      end
   end

   assign rsp_port.valid           = out_valid_ff;
   assign rsp_port.read_data       = rd_ff;
   assign rsp_port.addr_error      = err_ff;
   assign rsp_port.bank_out_enable = oe_ff;
   assign rsp_port.bank_out_value  = ov_ff;

   // Register file update
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < BANKS; b++) begin
            func_row_ff[b] <= '0;
            latch_ff[b]    <= '0;
            pull_ff[b]     <= '0;
         end
      end else if (advance && wr_ok) begin
         if (dec.is_func)
            func_row_ff[bidx] <= row_after;
         if (dec.is_data)
            latch_ff[bidx] <= s1_wdata_ff;
         if (dec.is_pull)
            pull_ff[bidx][dec.pull_sel] <= s1_wdata_ff;
      end
   end

   // Checks
   `GPR_ASSERT(a_adv_fills_out, clock, reset, advance |=> out_valid_ff,
      "result register not loaded after stage advance")
   `GPR_ASSERT(a_stall_cause, clock, reset,
      !req_port.ready |-> (s1_valid_ff && out_valid_ff && !rsp_port.ready),
      "request stalled without a full pipeline")
   `GPR_ASSERT(a_data_write_seen, clock, reset,
      (advance && wr_ok && dec.is_data) |=> (ov_ff == $past(s1_wdata_ff)),
      "data latch write not reflected in bank_out_value")
   `GPR_ASSERT_NORST(a_reset_empty, clock, reset |=> (!s1_valid_ff && !out_valid_ff),
      "pipeline not empty after reset")

endmodule
